/* rtl/gbu_pkg.sv */
// ----------------------------------------------------------------------------
// gbu_pkg
// Shared types, range tables and constants of the GB18030 four-byte range
// converter.
// ----------------------------------------------------------------------------
package gbu_pkg;

   // Direction codes.
   localparam logic OP_GB_TO_UTF8 = 1'b0;
   localparam logic OP_UTF8_TO_GB = 1'b1;

   localparam int RANGE_COUNT = 13;
   localparam int RANGE_IDX_W = $clog2(RANGE_COUNT);
   localparam int CP_W        = 21;
   localparam int INDEX_W     = 22;

   localparam int QUEUE_DEPTH = 2;

   // UTF-8 word length boundaries, on the packed word and on the code point.
   localparam logic [31:0] WORD_MAX_1 = 32'h0000_007F;
   localparam logic [31:0] WORD_MAX_2 = 32'h0000_FFFF;
   localparam logic [31:0] WORD_MAX_3 = 32'h00FF_FFFF;
   localparam logic [31:0] CP_MAX_1   = 32'h0000_007F;
   localparam logic [31:0] CP_MAX_2   = 32'h0000_07FF;
   localparam logic [31:0] CP_MAX_3   = 32'h0000_FFFF;

   // GB byte origins.
   localparam logic [7:0] GB_LEAD_BASE  = 8'h81;
   localparam logic [7:0] GB_DIGIT_BASE = 8'h30;

   // Round-up reciprocals: floor(n * M >> s) equals floor(n / d) for n < 2^21.
   localparam logic [20:0] RECIP_10     = 21'd1677722;  // s = 24
   localparam logic [21:0] RECIP_1260   = 22'd3408705;  // s = 32
   localparam logic [21:0] RECIP_12600  = 22'd2726964;  // s = 35

   localparam logic [31:0] RANGE_GB_LO [RANGE_COUNT] = '{
      32'h8130D330, 32'h8137A839, 32'h8230A633, 32'h8231D438, 32'h8232C937,
      32'h8233A339, 32'h8233E838, 32'h8234A131, 32'h82358F33, 32'h8336D030,
      32'h84309C38, 32'h8431A234, 32'h90308130
   };
   localparam logic [31:0] RANGE_GB_HI [RANGE_COUNT] = '{
      32'h8136A531, 32'h8138FD38, 32'h8230F237, 32'h8232AF32, 32'h8232F837,
      32'h8233C931, 32'h82349638, 32'h8234E733, 32'h8336C738, 32'h84308534,
      32'h84318537, 32'h8431A439, 32'hE3329A35
   };
   localparam logic [CP_W-1:0] RANGE_UNI_LO [RANGE_COUNT] = '{
      21'h000452, 21'h002643, 21'h00361B, 21'h003CE1, 21'h004160,
      21'h0044D7, 21'h00478E, 21'h0049B8, 21'h009FA6, 21'h00E865,
      21'h00FA2A, 21'h00FFE6, 21'h010000
   };
   localparam logic [CP_W-1:0] RANGE_UNI_HI [RANGE_COUNT] = '{
      21'h00200F, 21'h002E80, 21'h003917, 21'h004055, 21'h004336,
      21'h00464B, 21'h004946, 21'h004C76, 21'h00D7FF, 21'h00F92B,
      21'h00FE2F, 21'h00FFFF, 21'h10FFFF
   };

   typedef logic [INDEX_W-1:0] index_vec_type [RANGE_COUNT];
   typedef logic [CP_W-1:0]    cp_vec_type    [RANGE_COUNT];

   // Weighted byte sum of a packed four-byte code (12600/1260/10/1).
   function automatic logic [INDEX_W-1:0] gb_index(input logic [31:0] w);
      return INDEX_W'(w[31:24]) * INDEX_W'(12600) + INDEX_W'(w[23:16]) * INDEX_W'(1260)
           + INDEX_W'(w[15:8]) * INDEX_W'(10) + INDEX_W'(w[7:0]);
   endfunction

   localparam logic [INDEX_W-1:0] GB_INDEX_BASE = gb_index(32'h81308130);

   // Subtrahend that takes a GB weighted sum to a code point.
   function automatic index_vec_type calc_gb_offset();
      index_vec_type k;
      for (int i = 0; i < RANGE_COUNT; i++) begin
         k[i] = gb_index(RANGE_GB_LO[i]) - INDEX_W'(RANGE_UNI_LO[i]);
      end
      return k;
   endfunction

   // Addend that takes a code point to a linear GB index, modulo 2^21.
   function automatic cp_vec_type calc_cp_offset();
      cp_vec_type k;
      for (int i = 0; i < RANGE_COUNT; i++) begin
         k[i] = CP_W'(gb_index(RANGE_GB_LO[i]) - GB_INDEX_BASE
                      - INDEX_W'(RANGE_UNI_LO[i]));
      end
      return k;
   endfunction

   localparam index_vec_type RANGE_GB_OFFSET = calc_gb_offset();
   localparam cp_vec_type    RANGE_CP_OFFSET = calc_cp_offset();

   // One classified word as it travels from the front to the back.
   typedef struct packed {
      logic                   op;
      logic                   hit;
      logic [RANGE_IDX_W-1:0] rng;
      logic [31:0]            value;  // GB code, or the decoded code point
   } item_type;

endpackage

/* rtl/gbu_if.sv */
// ----------------------------------------------------------------------------
// gbu_req_if / gbu_rsp_if
// Valid/ready channels of the converter: request words in, result words out.
// ----------------------------------------------------------------------------
interface gbu_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] code_word;

   modport source (output valid, output op, output code_word, input ready);
   modport sink   (input valid, input op, input code_word, output ready);
endinterface

interface gbu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_word;
   logic        mapped;

   modport source (output valid, output result_word, output mapped, input ready);
   modport sink   (input valid, input result_word, input mapped, output ready);
endinterface

/* rtl/gbu_front.sv */
// ----------------------------------------------------------------------------
// gbu_front
// Takes request words, unpacks UTF-8 words to code points and finds the
// matching range, then hands the classified word to the queue.
// ----------------------------------------------------------------------------
module gbu_front (
   gbu_req_if.sink           req_chan,
   output logic              push_valid,
   output gbu_pkg::item_type push_item,
   input  logic              push_ready
);

   logic [gbu_pkg::CP_W-1:0]        cp;
   logic [31:0]                     key;
   logic                            hit;
   logic [gbu_pkg::RANGE_IDX_W-1:0] rng;

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;

   // Marker bits are ignored; the word's magnitude alone picks the length.
   always_comb begin
      cp = '0;
      if (req_chan.code_word <= gbu_pkg::WORD_MAX_1) begin
         cp = gbu_pkg::CP_W'(req_chan.code_word[6:0]);
      end else if (req_chan.code_word <= gbu_pkg::WORD_MAX_2) begin
         cp = gbu_pkg::CP_W'({req_chan.code_word[12:8], req_chan.code_word[5:0]});
      end else if (req_chan.code_word <= gbu_pkg::WORD_MAX_3) begin
         cp = gbu_pkg::CP_W'({req_chan.code_word[19:16], req_chan.code_word[13:8],
                              req_chan.code_word[5:0]});
      end else begin
         cp = {req_chan.code_word[26:24], req_chan.code_word[21:16],
               req_chan.code_word[13:8], req_chan.code_word[5:0]};
      end
   end

   assign key = (req_chan.op == gbu_pkg::OP_GB_TO_UTF8) ? req_chan.code_word : 32'(cp);

   // Ranges are disjoint; scanning downward leaves the lowest match.
   always_comb begin
      hit = 1'b0;
      rng = '0;
      for (int i = gbu_pkg::RANGE_COUNT - 1; i >= 0; i--) begin
         if (req_chan.op == gbu_pkg::OP_GB_TO_UTF8) begin
            if (key >= gbu_pkg::RANGE_GB_LO[i] && key <= gbu_pkg::RANGE_GB_HI[i]) begin
               hit = 1'b1;
               rng = gbu_pkg::RANGE_IDX_W'(i);
            end
         end else begin
            if (key >= 32'(gbu_pkg::RANGE_UNI_LO[i])
                && key <= 32'(gbu_pkg::RANGE_UNI_HI[i])) begin
               hit = 1'b1;
               rng = gbu_pkg::RANGE_IDX_W'(i);
            end
         end
      end
   end

   assign push_item.op    = req_chan.op;
   assign push_item.hit   = hit;
   assign push_item.rng   = rng;
   assign push_item.value = key;

endmodule

/* rtl/gbu_queue.sv */
// ----------------------------------------------------------------------------
// gbu_queue
// Short register FIFO between the classifying front and the compute back.
// ----------------------------------------------------------------------------
module gbu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  gbu_pkg::item_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output gbu_pkg::item_type pop_item,
   input  logic              pop_ready
);

   localparam int PTR_W = (gbu_pkg::QUEUE_DEPTH > 1) ? $clog2(gbu_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(gbu_pkg::QUEUE_DEPTH + 1);

   gbu_pkg::item_type entry_ff [gbu_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_W'(gbu_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(gbu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(gbu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/gbu_back.sv */
// ----------------------------------------------------------------------------
// gbu_back
// Three-stage elastic pipeline: weighted GB sum or offset code point, then the
// range subtraction or reciprocal divisions, then packing into the result word.
// ----------------------------------------------------------------------------
module gbu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  gbu_pkg::item_type pop_item,
   output logic              pop_ready,
   gbu_rsp_if.source         rsp_chan
);

   // Stage 1: weighted GB sum, or linear GB index.
   logic                            v1_ff, v1_in;
   logic                            op1_ff, hit1_ff;
   logic [gbu_pkg::RANGE_IDX_W-1:0] rng1_ff;
   logic [gbu_pkg::INDEX_W-1:0]     acc1_ff, acc1_in;

   // Stage 2: code point, or the three quotients of the linear index.
   logic                     v2_ff, v2_in;
   logic                     op2_ff, hit2_ff;
   logic [31:0]              u2_ff, u2_in;
   logic [gbu_pkg::CP_W-1:0] n2_ff;
   logic [17:0]              q10_ff, q10_in;
   logic [10:0]              q1260_ff, q1260_in;
   logic [7:0]               q12600_ff, q12600_in;
   logic [41:0]              prod10;
   logic [42:0]              prod1260, prod12600;

   // Stage 3: result register.
   logic        v3_ff, v3_in;
   logic [31:0] result_ff, result_in;
   logic        mapped_ff;

   logic        adv1, adv2, adv3;
   logic [31:0] utf_word, gb_word;
   logic [20:0] rem_d;
   logic [17:0] rem_c;
   logic [10:0] rem_b;

   // A stage takes new data when it is empty or its content moves on.
   assign adv3      = !v3_ff || rsp_chan.ready;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign pop_ready = adv1;

   assign v1_in = adv1 ? pop_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;

   always_comb begin
      if (pop_item.op == gbu_pkg::OP_GB_TO_UTF8) begin
         acc1_in = gbu_pkg::gb_index(pop_item.value);
      end else begin
         acc1_in = gbu_pkg::INDEX_W'(pop_item.value[gbu_pkg::CP_W-1:0]
                                     + gbu_pkg::RANGE_CP_OFFSET[pop_item.rng]);
      end
   end

   // Stage 2 arithmetic. The difference wraps modulo 2^32 for malformed bytes.
   assign u2_in     = 32'(acc1_ff) - 32'(gbu_pkg::RANGE_GB_OFFSET[rng1_ff]);
   assign prod10    = 42'(acc1_ff[gbu_pkg::CP_W-1:0]) * 42'(gbu_pkg::RECIP_10);
   assign prod1260  = 43'(acc1_ff[gbu_pkg::CP_W-1:0]) * 43'(gbu_pkg::RECIP_1260);
   assign prod12600 = 43'(acc1_ff[gbu_pkg::CP_W-1:0]) * 43'(gbu_pkg::RECIP_12600);
   assign q10_in    = prod10[41:24];
   assign q1260_in  = prod1260[42:32];
   assign q12600_in = prod12600[42:35];

   // Remainders give the low three GB bytes.
   assign rem_d = n2_ff - 21'(q10_ff) * 21'(10);
   assign rem_c = q10_ff - 18'(q1260_ff) * 18'(126);
   assign rem_b = q1260_ff - 11'(q12600_ff) * 11'(10);

   assign gb_word = {gbu_pkg::GB_LEAD_BASE + q12600_ff,
                     gbu_pkg::GB_DIGIT_BASE + {4'b0, rem_b[3:0]},
                     gbu_pkg::GB_LEAD_BASE + {1'b0, rem_c[6:0]},
                     gbu_pkg::GB_DIGIT_BASE + {4'b0, rem_d[3:0]}};

   always_comb begin
      if (u2_ff <= gbu_pkg::CP_MAX_1) begin
         utf_word = u2_ff;
      end else if (u2_ff <= gbu_pkg::CP_MAX_2) begin
         utf_word = {16'h0, 3'b110, u2_ff[10:6], 2'b10, u2_ff[5:0]};
      end else if (u2_ff <= gbu_pkg::CP_MAX_3) begin
         utf_word = {8'h0, 4'b1110, u2_ff[15:12], 2'b10, u2_ff[11:6], 2'b10, u2_ff[5:0]};
      end else begin
         utf_word = {5'b11110, u2_ff[20:18], 2'b10, u2_ff[17:12], 2'b10, u2_ff[11:6],
                     2'b10, u2_ff[5:0]};
      end
   end

   always_comb begin
      result_in = '0;
      if (hit2_ff) begin
         result_in = (op2_ff == gbu_pkg::OP_GB_TO_UTF8) ? utf_word : gb_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         op1_ff  <= pop_item.op;
         hit1_ff <= pop_item.hit;
         rng1_ff <= pop_item.rng;
         acc1_ff <= acc1_in;
      end
      if (adv2) begin
         op2_ff    <= op1_ff;
         hit2_ff   <= hit1_ff;
         u2_ff     <= u2_in;
         n2_ff     <= acc1_ff[gbu_pkg::CP_W-1:0];
         q10_ff    <= q10_in;
         q1260_ff  <= q1260_in;
         q12600_ff <= q12600_in;
      end
      if (adv3) begin
         result_ff <= result_in;
         mapped_ff <= hit2_ff;
      end
   end

   assign rsp_chan.valid       = v3_ff;
   assign rsp_chan.result_word = result_ff;
   assign rsp_chan.mapped      = mapped_ff;

endmodule

/* rtl/gb18030_utf8_range_converter_unit.sv */
// ----------------------------------------------------------------------------
// gb18030_utf8_range_converter_unit
// Converts packed four-byte GB18030 codes in the thirteen numeric ranges to
// UTF-8 words and back.
// ----------------------------------------------------------------------------
// Path: an accepted word is stored in the queue, then passes stages 1, 2 and 3.
// Throughput: one word per cycle while the result side does not stall, set by the three-stage compute pipeline.
// Reset: synchronous; empties the queue and all pipeline stages, no clear pass.
module gb18030_utf8_range_converter_unit (
   input  logic      clock,
   input  logic      reset,
   gbu_req_if.sink   req_chan,
   gbu_rsp_if.source rsp_chan
);

   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;
   gbu_pkg::item_type push_item, pop_item;

   gbu_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   gbu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   gbu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

/* rtl/gbu_checker.sv */
// ----------------------------------------------------------------------------
// gbu_checker
// Port-level checks of the converter's result channel and reset behavior.
// ----------------------------------------------------------------------------
module gbu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result_word,
   input logic        rsp_mapped
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result_word) && $stable(rsp_mapped))
      else $error("result word changed while stalled");

   a_unmapped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mapped |-> rsp_result_word == 32'h0)
      else $error("unmapped word carries a nonzero result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("converter not empty and ready after reset");

endmodule

bind gb18030_utf8_range_converter_unit gbu_checker u_gbu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_result_word (rsp_chan.result_word),
   .rsp_mapped      (rsp_chan.mapped)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the GB18030 four-byte range converter. Words are
// pushed through the request channel under varying idle patterns, every
// accepted word is predicted by a model of the thirteen-range mapping, and
// every result word is compared in order against that prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NUM_RANGES  = 13;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_WORDS = 585;

   localparam logic [31:0] TAB_GB_LO [NUM_RANGES] = '{
      32'h8130D330, 32'h8137A839, 32'h8230A633, 32'h8231D438, 32'h8232C937,
      32'h8233A339, 32'h8233E838, 32'h8234A131, 32'h82358F33, 32'h8336D030,
      32'h84309C38, 32'h8431A234, 32'h90308130
   };
   localparam logic [31:0] TAB_GB_HI [NUM_RANGES] = '{
      32'h8136A531, 32'h8138FD38, 32'h8230F237, 32'h8232AF32, 32'h8232F837,
      32'h8233C931, 32'h82349638, 32'h8234E733, 32'h8336C738, 32'h84308534,
      32'h84318537, 32'h8431A439, 32'hE3329A35
   };
   localparam logic [31:0] TAB_UNI_LO [NUM_RANGES] = '{
      32'h0452, 32'h2643, 32'h361B, 32'h3CE1, 32'h4160, 32'h44D7, 32'h478E,
      32'h49B8, 32'h9FA6, 32'hE865, 32'hFA2A, 32'hFFE6, 32'h10000
   };
   localparam logic [31:0] TAB_UNI_HI [NUM_RANGES] = '{
      32'h200F, 32'h2E80, 32'h3917, 32'h4055, 32'h4336, 32'h464B, 32'h4946,
      32'h4C76, 32'hD7FF, 32'hF92B, 32'hFE2F, 32'hFFFF, 32'h10FFFF
   };

   class conversion_scoreboard;
      typedef struct {
         logic [31:0] word;
         logic        mapped;
      } conv_result_type;

      conv_result_type awaited_q[$];
      int errors;
      int n_gb_words;
      int n_utf_words;
      int n_checked;
      int n_mapped;

      function new();
         errors      = 0;
         n_gb_words  = 0;
         n_utf_words = 0;
         n_checked   = 0;
         n_mapped    = 0;
      endfunction

      // Weighted byte sum of a packed GB code, wrapping at 32 bits.
      function logic [31:0] weighted(logic [31:0] w);
         return 32'(w[31:24]) * 32'd12600 + 32'(w[23:16]) * 32'd1260
              + 32'(w[15:8]) * 32'd10 + 32'(w[7:0]);
      endfunction

      function logic [31:0] encode_utf8(logic [31:0] u);
         if (u <= 32'h7F) return u;
         if (u <= 32'h7FF) return {16'h0, 3'b110, u[10:6], 2'b10, u[5:0]};
         if (u <= 32'hFFFF)
            return {8'h0, 4'hE, u[15:12], 2'b10, u[11:6], 2'b10, u[5:0]};
         return {5'b11110, u[20:18], 2'b10, u[17:12], 2'b10, u[11:6], 2'b10, u[5:0]};
      endfunction

      // Marker bits are ignored; the length is picked from the magnitude.
      function logic [31:0] decode_utf8(logic [31:0] w);
         if (w <= 32'h7F) return w;
         if (w <= 32'hFFFF) return {21'h0, w[12:8], w[5:0]};
         if (w <= 32'hFFFFFF) return {16'h0, w[19:16], w[13:8], w[5:0]};
         return {11'h0, w[26:24], w[21:16], w[13:8], w[5:0]};
      endfunction

      function logic [31:0] split_gb(logic [31:0] n);
         logic [31:0] a, b, c, d;
         a = (32'h81 + n / 32'd12600) & 32'hFF;
         b = 32'h30 + (n / 32'd1260) % 32'd10;
         c = 32'h81 + (n / 32'd10) % 32'd126;
         d = 32'h30 + n % 32'd10;
         return {a[7:0], b[7:0], c[7:0], d[7:0]};
      endfunction

      function conv_result_type convert(logic op, logic [31:0] w);
         conv_result_type r;
         logic [31:0]     u;
         logic [31:0]     gb_base;
         r.word   = 32'h0;
         r.mapped = 1'b0;
         gb_base  = weighted(32'h81308130);
         if (op == gbu_pkg::OP_GB_TO_UTF8) begin
            for (int i = 0; i < NUM_RANGES; i++) begin
               if (!r.mapped && w >= TAB_GB_LO[i] && w <= TAB_GB_HI[i]) begin
                  u        = weighted(w) - weighted(TAB_GB_LO[i]) + TAB_UNI_LO[i];
                  r.word   = encode_utf8(u);
                  r.mapped = 1'b1;
               end
            end
         end else begin
            u = decode_utf8(w);
            for (int i = 0; i < NUM_RANGES; i++) begin
               if (!r.mapped && u >= TAB_UNI_LO[i] && u <= TAB_UNI_HI[i]) begin
                  r.word   = split_gb(u - TAB_UNI_LO[i] + weighted(TAB_GB_LO[i]) - gb_base);
                  r.mapped = 1'b1;
               end
            end
         end
         return r;
      endfunction

      function void note_input(logic op, logic [31:0] w);
         awaited_q.push_back(convert(op, w));
         if (op == gbu_pkg::OP_GB_TO_UTF8) n_gb_words++;
         else n_utf_words++;
      endfunction

      function void check_result(logic [31:0] word, logic mapped);
         conv_result_type e;
         if (awaited_q.size() == 0) begin
            $error("unexpected result word %h (mapped %0b)", word, mapped);
            errors++;
            return;
         end
         e = awaited_q.pop_front();
         n_checked++;
         if (e.mapped) n_mapped++;
         if (word !== e.word) begin
            $error("result_word: expected %h, actual %h", e.word, word);
            errors++;
         end
         if (mapped !== e.mapped) begin
            $error("mapped: expected %0b, actual %0b", e.mapped, mapped);
            errors++;
         end
      endfunction

      function int outstanding();
         return awaited_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   hold_seq;
   int   hold_seen;
   int   hold_left;
   int   quiet_cycles;

   conversion_scoreboard sb;

   gbu_req_if req_chan();
   gbu_rsp_if rsp_chan();

   gb18030_utf8_range_converter_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one word, with random idle cycles ahead of it, and waits for it
   // to be taken.
   task automatic send_word(input logic op, input logic [31:0] w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.op        <= op;
      req_chan.code_word <= w;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_input(op, w);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (sb.outstanding() > 0) @(posedge clock);
   endtask

   task automatic send_random_word();
      int          kind;
      int          k;
      logic [31:0] w;
      logic [31:0] span;
      kind = $urandom_range(0, 99);
      k    = $urandom_range(0, NUM_RANGES - 1);
      if (kind < 35) begin
         // Well-formed GB code somewhere inside one range.
         span = sb.weighted(TAB_GB_HI[k]) - sb.weighted(TAB_GB_LO[k]);
         w = sb.split_gb(sb.weighted(TAB_GB_LO[k]) - sb.weighted(32'h81308130)
                         + $urandom_range(0, span));
         send_word(gbu_pkg::OP_GB_TO_UTF8, w);
      end else if (kind < 45) begin
         case ($urandom_range(0, 3))
            0: w = TAB_GB_LO[k];
            1: w = TAB_GB_HI[k];
            2: w = TAB_GB_LO[k] - 32'd1;
            default: w = TAB_GB_HI[k] + 32'd1;
         endcase
         send_word(gbu_pkg::OP_GB_TO_UTF8, w);
      end else if (kind < 75) begin
         send_word(gbu_pkg::OP_UTF8_TO_GB,
                   sb.encode_utf8($urandom_range(TAB_UNI_LO[k], TAB_UNI_HI[k])));
      end else if (kind < 82) begin
         case ($urandom_range(0, 3))
            0: w = TAB_UNI_LO[k];
            1: w = TAB_UNI_HI[k];
            2: w = TAB_UNI_LO[k] - 32'd1;
            default: w = TAB_UNI_HI[k] + 32'd1;
         endcase
         send_word(gbu_pkg::OP_UTF8_TO_GB, sb.encode_utf8(w));
      end else if (kind < 88) begin
         send_word(gbu_pkg::OP_UTF8_TO_GB, sb.encode_utf8($urandom_range(0, 32'h10FFFF)));
      end else if (kind < 93) begin
         // Raw words inside a GB interval, most of them with malformed bytes.
         w = TAB_GB_LO[k] + $urandom_range(0, TAB_GB_HI[k] - TAB_GB_LO[k]);
         send_word(gbu_pkg::OP_GB_TO_UTF8, w);
      end else begin
         send_word(1'($urandom_range(0, 1)), $urandom());
      end
   endtask

   // Result side: checks each accepted word and picks the next ready level.
   initial begin
      rsp_chan.ready = 1'b0;
      hold_seen      = 0;
      hold_left      = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            sb.check_result(rsp_chan.result_word, rsp_chan.mapped);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Ends the run when neither channel has moved a word for too long.
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] gb_dir  [$];
      logic [31:0] utf_dir [$];
      sb                 = new();
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.op        = gbu_pkg::OP_GB_TO_UTF8;
      req_chan.code_word = 32'h0;
      send_idle_pct      = 30;
      recv_idle_pct      = 72;
      hold_seq           = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Range edges, words just outside them, malformed bytes inside a
      // numeric range, and the all-zero and all-one words.
      gb_dir = '{32'h8130D330, 32'h8136A531, 32'h8130D32F, 32'h8136A532,
                 32'h82358F33, 32'h8431A439, 32'h90308130, 32'hE3329A35,
                 32'hE3329A36, 32'h81310000, 32'h9030FFFF, 32'h00000000,
                 32'hFFFFFFFF};
      // Boundary code points, unmapped neighbors, and UTF-8 words whose
      // marker bits are wrong.
      utf_dir = '{32'h00000000, 32'h0000007F, 32'h0000D192, 32'h0000D191,
                  32'h00E2808F, 32'h00E28090, 32'h00EFBFBF, 32'hF0908080,
                  32'hF48FBFBF, 32'hFFFFFFFF, 32'h00001192, 32'h7FFFFFFF};
      foreach (gb_dir[i]) send_word(gbu_pkg::OP_GB_TO_UTF8, gb_dir[i]);
      foreach (utf_dir[i]) send_word(gbu_pkg::OP_UTF8_TO_GB, utf_dir[i]);
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 30; recv_idle_pct = 72; end
            1: begin send_idle_pct = 72; recv_idle_pct = 30; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // With no idling, a long result stall backs up the whole pipe.
            if (phase == 2 && n == 150) hold_seq <= hold_seq + 1;
            send_random_word();
         end
         // Sender pauses here until every result of the phase has come back.
         drain_results();
      end

      repeat (10) @(posedge clock);
      $display("Converted %0d GB words and %0d UTF-8 words; %0d results checked, %0d mapped.",
               sb.n_gb_words, sb.n_utf_words, sb.n_checked, sb.n_mapped);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
